// ===== src/tcbp_pkg.sv =====
// ============================================================================
// tcbp_pkg
// Shared types, constants and helpers of the top-k cutoff partner tracker.
// ============================================================================
package tcbp_pkg;

    localparam int TOP_BIN    = 63;
    localparam int ITEM_COUNT = 1024;
    localparam int FRAC_BITS  = 8;

    localparam int BIN_COUNT = TOP_BIN + 1;
    localparam int BIN_W     = $clog2(BIN_COUNT);
    localparam int ITEM_W    = $clog2(ITEM_COUNT);
    localparam int SCORE_W   = 16;
    localparam int IDX_W     = 10;
    localparam int TOPK_W    = 16;
    localparam int CUT_W     = 6;
    localparam int COUNT_W   = 32;
    localparam int SUM_W     = COUNT_W + BIN_W;
    localparam int CMP_W     = (BIN_W + FRAC_BITS > SCORE_W) ? BIN_W + FRAC_BITS : SCORE_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_K      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CUTOFF = 1'b1;

    localparam logic [TOPK_W-1:0] TOP_K_RESET = 16'd100;
    localparam logic [CUT_W-1:0]  CUTOFF_RESET = 6'd0;

    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [BIN_W-1:0]   t_bin;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
        t_score           score;
    } t_in_word;

    typedef struct packed {
        logic             improved;
        logic [CUT_W-1:0] cutoff_now;
    } t_out_word;

    typedef struct packed {
        t_score           score;
        logic [IDX_W-1:0] partner;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_ISSUE = 6'b000100,
        S_RMW_A = 6'b001000,
        S_RMW_B = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // True when the score lies strictly above the integer cutoff.
    function automatic logic score_above(t_score s, t_bin c);
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        lhs = CMP_W'(s);
        rhs = CMP_W'(c) << FRAC_BITS;
        return lhs > rhs;
    endfunction

    // Histogram bin of a score: its integer part, clamped at the top bin.
    function automatic t_bin bin_of(t_score s);
        t_score whole;
        whole = s >> FRAC_BITS;
        if (whole > t_score'(TOP_BIN)) begin
            return t_bin'(TOP_BIN);
        end
        return t_bin'(whole);
    endfunction

endpackage

// ===== src/tcbp_ram.sv =====
// ============================================================================
// tcbp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module tcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/topk_cutoff_best_partner_tracker_top.sv =====
// ============================================================================
// topk_cutoff_best_partner_tracker_top
// Score cutoff tracker with a histogram of scores and a best-partner table.
// ============================================================================
// An accepted score passes S_RMW_A and S_RMW_B, a rejected one S_OUT, before its
// result word is registered; the next word is taken only back in S_IDLE. Accepted
// words make two read-modify-writes through the one read port of the partner
// table; a histogram rescan (S_SCAN, S_ISSUE) comes first once the insert count
// reaches top_k. Reset: a clearing pass zeroes the histogram and sets the
// ITEM_COUNT (1024) table entries to score zero, partner all ones; no input
// word is taken during it, configuration writes are taken throughout.
module topk_cutoff_best_partner_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tcbp_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tcbp_pkg::t_out_word                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcbp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcbp_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    // ------------------------------------------------------------------------
    // Registers and their next values.
    // ------------------------------------------------------------------------
    tcbp_pkg::t_state                r_state,     n_state;
    logic                            r_clr_busy,  n_clr_busy;
    logic [tcbp_pkg::ITEM_W-1:0]     r_clr_idx,   n_clr_idx;
    logic [tcbp_pkg::TOPK_W-1:0]     r_top_k,     n_top_k;
    tcbp_pkg::t_bin                  r_cutoff,    n_cutoff;
    logic [tcbp_pkg::TOPK_W-1:0]     r_ins,       n_ins;
    tcbp_pkg::t_in_word              r_in,        n_in;
    tcbp_pkg::t_bin                  r_scan_idx,  n_scan_idx;
    logic                            r_scan_pend, n_scan_pend;
    tcbp_pkg::t_bin                  r_scan_pidx, n_scan_pidx;
    logic [tcbp_pkg::SUM_W-1:0]      r_sum,       n_sum;
    logic                            r_fwd,       n_fwd;
    logic                            r_imp,       n_imp;
    logic                            r_out_valid, n_out_valid;
    tcbp_pkg::t_out_word             r_out,       n_out;

    // ------------------------------------------------------------------------
    // Memory ports.
    // ------------------------------------------------------------------------
    logic                            bin_we;
    tcbp_pkg::t_bin                  bin_waddr;
    tcbp_pkg::t_count                bin_wdata;
    tcbp_pkg::t_bin                  bin_raddr;
    tcbp_pkg::t_count                bin_rdata;

    logic                            tbl_we;
    logic [tcbp_pkg::ITEM_W-1:0]     tbl_waddr;
    tcbp_pkg::t_entry                tbl_wdata;
    logic [tcbp_pkg::ITEM_W-1:0]     tbl_raddr;
    tcbp_pkg::t_entry                tbl_rdata;

    // Histogram of accepted scores, one count per integer bin.
    tcbp_ram #(
        .WIDTH ($bits(tcbp_pkg::t_count)),
        .DEPTH (tcbp_pkg::BIN_COUNT)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rdata)
    );

    // Best score and best partner of every item, kept side by side.
    tcbp_ram #(
        .WIDTH ($bits(tcbp_pkg::t_entry)),
        .DEPTH (tcbp_pkg::ITEM_COUNT)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // ------------------------------------------------------------------------
    // Handshakes.
    // ------------------------------------------------------------------------
    logic in_acc;
    logic cfg_acc;
    logic out_free;

    assign o_in_ready  = (r_state == tcbp_pkg::S_IDLE) && !r_clr_busy;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    // The result register can be loaded when it is empty or being emptied.
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // Datapath helpers.
    // ------------------------------------------------------------------------
    tcbp_pkg::t_in_word          iss_word;    // word whose first reads go out
    logic                        iss_above;   // its score passes the cutoff
    tcbp_pkg::t_bin              cur_bin;     // bin of the word being updated
    logic [tcbp_pkg::SUM_W-1:0]  sum_new;     // rescan running sum
    logic                        scan_issue;  // rescan reads another bin
    logic                        scan_hit;    // running sum passed top_k
    tcbp_pkg::t_count            bin_next;    // saturating bin increment
    logic                        imp_a;
    logic                        imp_b;

    assign iss_word   = (r_state == tcbp_pkg::S_IDLE) ? i_in_data : r_in;
    assign iss_above  = tcbp_pkg::score_above(iss_word.score, r_cutoff);
    assign cur_bin    = tcbp_pkg::bin_of(r_in.score);
    assign sum_new    = r_sum + tcbp_pkg::SUM_W'(bin_rdata);
    assign scan_issue = r_scan_idx > r_cutoff;
    assign scan_hit   = r_scan_pend && (sum_new > tcbp_pkg::SUM_W'(r_top_k));
    assign bin_next   = (bin_rdata == '1) ? bin_rdata : bin_rdata + 1'b1;
    assign imp_a      = r_in.score > tbl_rdata.score;
    // When both indices name the same item, the first update already holds
    // this score, so the second check cannot pass.
    assign imp_b      = !r_fwd && (r_in.score > tbl_rdata.score);

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr_busy  = r_clr_busy;
        n_clr_idx   = r_clr_idx;
        n_top_k     = r_top_k;
        n_cutoff    = r_cutoff;
        n_ins       = r_ins;
        n_in        = r_in;
        n_scan_idx  = r_scan_idx;
        n_scan_pend = r_scan_pend;
        n_scan_pidx = r_scan_pidx;
        n_sum       = r_sum;
        n_fwd       = r_fwd;
        n_imp       = r_imp;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        bin_we    = 1'b0;
        bin_waddr = cur_bin;
        bin_wdata = bin_next;
        bin_raddr = tcbp_pkg::bin_of(iss_word.score);
        tbl_we    = 1'b0;
        tbl_waddr = r_in.first_index;
        tbl_wdata = '{score: r_in.score, partner: r_in.second_index};
        tbl_raddr = iss_word.first_index;

        // Clearing pass after reset: one table entry, and while the index is
        // in range one histogram bin, per cycle.
        if (r_clr_busy) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_clr_idx;
            tbl_wdata = '{score: '0, partner: '1};
            bin_we    = r_clr_idx < tcbp_pkg::ITEM_W'(tcbp_pkg::BIN_COUNT);
            bin_waddr = tcbp_pkg::BIN_W'(r_clr_idx);
            bin_wdata = '0;
            n_clr_idx = r_clr_idx + 1'b1;
            if (r_clr_idx == tcbp_pkg::ITEM_W'(tcbp_pkg::ITEM_COUNT - 1)) begin
                n_clr_busy = 1'b0;
            end
        end

        case (r_state)
            tcbp_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_in = i_in_data;
                    if (r_ins == r_top_k) begin
                        n_state     = tcbp_pkg::S_SCAN;
                        n_scan_idx  = tcbp_pkg::BIN_W'(tcbp_pkg::TOP_BIN);
                        n_scan_pend = 1'b0;
                        n_sum       = '0;
                        n_ins       = '0;
                    end else if (iss_above) begin
                        n_state = tcbp_pkg::S_RMW_A;
                    end else begin
                        n_imp   = 1'b0;
                        n_state = tcbp_pkg::S_OUT;
                    end
                end
            end
            tcbp_pkg::S_SCAN: begin
                bin_raddr = r_scan_idx;
                if (r_scan_pend) begin
                    n_sum = sum_new;
                end
                if (scan_hit) begin
                    n_cutoff = r_scan_pidx;
                    n_state  = tcbp_pkg::S_ISSUE;
                end else if (!scan_issue && !r_scan_pend) begin
                    n_state = tcbp_pkg::S_ISSUE;
                end else begin
                    n_scan_pend = scan_issue;
                    n_scan_pidx = r_scan_idx;
                    if (scan_issue) begin
                        n_scan_idx = r_scan_idx - 1'b1;
                    end
                end
            end
            tcbp_pkg::S_ISSUE: begin
                if (iss_above) begin
                    n_state = tcbp_pkg::S_RMW_A;
                end else begin
                    n_imp   = 1'b0;
                    n_state = tcbp_pkg::S_OUT;
                end
            end
            tcbp_pkg::S_RMW_A: begin
                bin_we    = 1'b1;
                tbl_raddr = r_in.second_index;
                n_ins     = r_ins + 1'b1;
                if (bin_next >= tcbp_pkg::COUNT_W'(r_top_k)) begin
                    n_cutoff = cur_bin;
                end
                tbl_we = imp_a;
                n_imp  = imp_a;
                n_fwd  = imp_a && (r_in.second_index == r_in.first_index);
                n_state = tcbp_pkg::S_RMW_B;
            end
            tcbp_pkg::S_RMW_B: begin
                tbl_we    = imp_b;
                tbl_waddr = r_in.second_index;
                tbl_wdata = '{score: r_in.score, partner: r_in.first_index};
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{improved: r_imp || imp_b,
                                    cutoff_now: tcbp_pkg::CUT_W'(r_cutoff)};
                    n_state     = tcbp_pkg::S_IDLE;
                end else begin
                    n_imp   = r_imp || imp_b;
                    n_state = tcbp_pkg::S_OUT;
                end
            end
            tcbp_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{improved: r_imp,
                                    cutoff_now: tcbp_pkg::CUT_W'(r_cutoff)};
                    n_state     = tcbp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcbp_pkg::S_IDLE;
            end
        endcase

        // Configuration writes must arrive only while no word is in flight; the block does not enforce this.
        if (cfg_acc) begin
            case (i_cfg_index)
                tcbp_pkg::CFG_TOP_K: begin
                    n_top_k = i_cfg_data;
                end
                tcbp_pkg::CFG_INIT_CUTOFF: begin
                    n_cutoff = tcbp_pkg::BIN_W'(i_cfg_data[tcbp_pkg::CUT_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcbp_pkg::S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_top_k     <= tcbp_pkg::TOP_K_RESET;
            r_cutoff    <= tcbp_pkg::BIN_W'(tcbp_pkg::CUTOFF_RESET);
            r_ins       <= '0;
            r_scan_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_busy  <= n_clr_busy;
            r_clr_idx   <= n_clr_idx;
            r_top_k     <= n_top_k;
            r_cutoff    <= n_cutoff;
            r_ins       <= n_ins;
            r_scan_pend <= n_scan_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_scan_idx  <= n_scan_idx;
        r_scan_pidx <= n_scan_pidx;
        r_sum       <= n_sum;
        r_fwd       <= n_fwd;
        r_imp       <= n_imp;
        r_out       <= n_out;
    end

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_no_result_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_out_valid
    ) else $error("result word shown during the clearing pass");

    a_scan_never_lowers_cutoff: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcbp_pkg::S_SCAN) && !i_cfg_valid |=> r_cutoff >= $past(r_cutoff)
    ) else $error("rescan lowered the cutoff");

    a_same_item_written_once: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcbp_pkg::S_RMW_B) && r_fwd |-> !tbl_we
    ) else $error("same item updated twice for one pair");

    a_bin_count_grows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcbp_pkg::S_RMW_A) && !r_clr_busy |-> bin_wdata >= bin_rdata
    ) else $error("histogram count decreased");

endmodule

// ===== dv/topk_cutoff_best_partner_tracker_top_test.sv =====
// ============================================================================
// topk_cutoff_best_partner_tracker_top_test
// Self-checking bench for the top-k cutoff tracker. It sends scored pairs and
// register writes over valid/ready channels with random gaps on both sides.
// Each result word is checked against a prediction from the bench's own copy
// of the histogram, the cutoff, the insert count and the best-score table.
// ============================================================================
module topk_cutoff_best_partner_tracker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    // The longest quiet stretch in a correct run is the clearing pass after
    // reset over every table entry. Gaps, stalls and a rescan stay far below this.
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_GAP      = 12;
    localparam int PHASE_PAIRS  = 200;
    localparam int PHASE_COUNT  = 8;
    localparam int LOW_K_PHASE  = 3;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the tracker state and holds the result words that
    // are still due, oldest first.
    // ------------------------------------------------------------------------
    class cutoff_scoreboard;
        tcbp_pkg::t_count            bin_counts [tcbp_pkg::BIN_COUNT];
        tcbp_pkg::t_score            best_score [tcbp_pkg::ITEM_COUNT];
        logic [tcbp_pkg::IDX_W-1:0]  best_partner [tcbp_pkg::ITEM_COUNT];
        tcbp_pkg::t_bin              cutoff;
        logic [tcbp_pkg::TOPK_W-1:0] top_k;
        logic [15:0]                 inserts;
        tcbp_pkg::t_out_word         expected_words [$];
        int                          errors;
        int                          pairs;
        int                          accepted;
        int                          rescans;
        int                          improvements;
        int                          reg_writes;

        function new();
            foreach (bin_counts[i]) bin_counts[i] = '0;
            foreach (best_score[i]) best_score[i] = '0;
            foreach (best_partner[i]) best_partner[i] = '1;
            top_k        = tcbp_pkg::TOP_K_RESET;
            cutoff       = tcbp_pkg::t_bin'(tcbp_pkg::CUTOFF_RESET);
            inserts      = '0;
            errors       = 0;
            pairs        = 0;
            accepted     = 0;
            rescans      = 0;
            improvements = 0;
            reg_writes   = 0;
        endfunction

        function void write_reg(input logic [tcbp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tcbp_pkg::CFG_DAT_W-1:0] value);
            reg_writes++;
            case (idx)
                tcbp_pkg::CFG_TOP_K: begin
                    top_k = tcbp_pkg::TOPK_W'(value);
                end
                tcbp_pkg::CFG_INIT_CUTOFF: begin
                    cutoff = tcbp_pkg::t_bin'(value[tcbp_pkg::CUT_W-1:0]);
                end
                default: begin
                end
            endcase
        endfunction

        // Replaces an item's best partner when the score is strictly higher.
        function bit raise_best(input logic [tcbp_pkg::IDX_W-1:0] item,
                                input logic [tcbp_pkg::IDX_W-1:0] partner,
                                input tcbp_pkg::t_score sc);
            if (sc > best_score[item]) begin
                best_score[item]   = sc;
                best_partner[item] = partner;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_pair(input tcbp_pkg::t_in_word w);
            logic [63:0]         running;
            int                  b;
            tcbp_pkg::t_bin      bin;
            tcbp_pkg::t_score    whole;
            tcbp_pkg::t_out_word res;
            pairs++;
            res.improved = 1'b0;
            if (inserts == top_k) begin
                rescans++;
                running = '0;
                for (b = tcbp_pkg::TOP_BIN; b > int'(cutoff); b--) begin
                    running += 64'(bin_counts[b]);
                    if (running > 64'(top_k)) begin
                        cutoff = tcbp_pkg::t_bin'(b);
                        break;
                    end
                end
                inserts = '0;
            end
            if (32'(w.score) > (32'(cutoff) << tcbp_pkg::FRAC_BITS)) begin
                accepted++;
                whole = w.score >> tcbp_pkg::FRAC_BITS;
                bin = (whole > tcbp_pkg::t_score'(tcbp_pkg::TOP_BIN)) ?
                      tcbp_pkg::t_bin'(tcbp_pkg::TOP_BIN) : tcbp_pkg::t_bin'(whole);
                inserts++;
                if (bin_counts[bin] != '1) bin_counts[bin]++;
                if (bin_counts[bin] >= 32'(top_k)) cutoff = bin;
                if (raise_best(w.first_index, w.second_index, w.score)) res.improved = 1'b1;
                if (raise_best(w.second_index, w.first_index, w.score)) res.improved = 1'b1;
            end
            if (res.improved) improvements++;
            res.cutoff_now = tcbp_pkg::CUT_W'(cutoff);
            expected_words = {expected_words, res};
        endfunction

        function void check_word(input tcbp_pkg::t_out_word got);
            tcbp_pkg::t_out_word want;
            if (expected_words.size() == 0) begin
                $error("result word with none due: improved %0b, cutoff_now %0d",
                       got.improved, got.cutoff_now);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.improved !== want.improved) begin
                $error("improved: expected %0b, actual %0b", want.improved, got.improved);
                errors++;
            end
            if (got.cutoff_now !== want.cutoff_now) begin
                $error("cutoff_now: expected %0d, actual %0d",
                       want.cutoff_now, got.cutoff_now);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    tcbp_pkg::t_in_word             in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    tcbp_pkg::t_out_word            out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tcbp_pkg::CFG_IDX_W-1:0] cfg_index = tcbp_pkg::CFG_TOP_K;
    logic [tcbp_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

    // Idling modes of the two sides. Each flips now and then, so that runs of
    // back-to-back words alternate with runs of random gaps.
    bit in_lazy  = 1'b1;
    bit out_lazy = 1'b0;

    int idle_cycles = 0;

    cutoff_scoreboard board = new();

    always #(CLK_PERIOD / 2) clk = ~clk;

    topk_cutoff_best_partner_tracker_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no word moves on any channel for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("topk_cutoff_best_partner_tracker_top_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. All inputs change at the falling edge; handshakes are sampled
    // at the rising edge, where the block's outputs still hold the values of
    // the cycle that ends there.
    // ------------------------------------------------------------------------

    // Draws the sender's gap before the next word.
    function automatic int next_gap();
        if ($urandom_range(0, 29) == 0) in_lazy = !in_lazy;
        if (!in_lazy) return 0;
        return int'($urandom_range(0, MAX_GAP));
    endfunction

    // Writes one register. Only called while the block holds no pending work.
    task automatic write_register(input logic [tcbp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tcbp_pkg::CFG_DAT_W-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Presents one pair word and waits until it is taken. Valid stays high on
    // return, so a following word with no gap goes out without a bubble.
    task automatic send_pair(input tcbp_pkg::t_in_word w, input int gap);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = w;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        board.note_pair(w);
        @(negedge clk);
    endtask

    task automatic offer_pair(input logic [tcbp_pkg::IDX_W-1:0] a,
                              input logic [tcbp_pkg::IDX_W-1:0] b,
                              input tcbp_pkg::t_score s);
        tcbp_pkg::t_in_word w;
        w.first_index  = a;
        w.second_index = b;
        w.score        = s;
        send_pair(w, next_gap());
    endtask

    // Holds the sender back until every result word has come, then waits longer
    // so the block is surely idle before any register write.
    task automatic drain_results();
        in_valid = 1'b0;
        while (board.expected_words.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random pair. Scores crowd around the current cutoff, where acceptance
    // flips, with a share of fully random and high scores. A band of low item
    // indices is reused often, so best scores get both beaten and defended.
    function automatic tcbp_pkg::t_in_word make_pair();
        tcbp_pkg::t_in_word w;
        int                 base;
        int                 s;
        int                 pick;
        base = int'(board.cutoff) << tcbp_pkg::FRAC_BITS;
        pick = int'($urandom_range(0, 99));
        if (pick < 30) begin
            s = base + int'($urandom_range(1, 300));
        end else if (pick < 45) begin
            s = base - int'($urandom_range(0, 40));
        end else if (pick < 80) begin
            s = int'($urandom_range(0, 65535));
        end else begin
            s = int'($urandom_range(32'(base), 65535));
        end
        if (s < 0) s = 0;
        if (s > 65535) s = 65535;
        w.score = tcbp_pkg::t_score'(s);
        pick = int'($urandom_range(0, 99));
        if (pick < 55) begin
            w.first_index  = tcbp_pkg::IDX_W'($urandom);
            w.second_index = tcbp_pkg::IDX_W'($urandom);
        end else if (pick < 85) begin
            w.first_index  = tcbp_pkg::IDX_W'($urandom_range(0, 15));
            w.second_index = tcbp_pkg::IDX_W'($urandom_range(0, 15));
        end else begin
            w.first_index  = tcbp_pkg::IDX_W'($urandom);
            w.second_index = w.first_index;
        end
        return w;
    endfunction

    // Hand-picked words: field extremes, the acceptance boundary at several
    // cutoffs, top-bin clamping, equal and lower scores, the same item on both
    // sides, and a zero top_k written while the insert count is above it.
    task automatic run_directed();
        offer_pair(10'd0, 10'd1023, 16'h0000);     // zero never beats a zero cutoff
        offer_pair(10'd0, 10'd1023, 16'h0001);     // smallest passing score
        offer_pair(10'd0, 10'd1023, 16'h0001);     // equal score is no improvement
        offer_pair(10'd1023, 10'd0, 16'hFFFF);     // clamps into the top bin
        offer_pair(10'd5, 10'd5, 16'h0305);        // same item twice in one pair
        offer_pair(10'd5, 10'd6, 16'h0200);        // lower for item 5, new for item 6
        offer_pair(10'h2AA, 10'h155, 16'hAAAA);
        offer_pair(10'h155, 10'h2AA, 16'h5555);
        drain_results();
        write_register(tcbp_pkg::CFG_INIT_CUTOFF, 16'd3);
        offer_pair(10'd10, 10'd11, 16'h0300);      // exactly on the cutoff: rejected
        offer_pair(10'd10, 10'd11, 16'h0301);
        offer_pair(10'd12, 10'd13, 16'h03FF);
        drain_results();
        write_register(tcbp_pkg::CFG_INIT_CUTOFF, 16'd63);
        offer_pair(10'd20, 10'd21, 16'h3F00);      // on the highest cutoff: rejected
        offer_pair(10'd20, 10'd21, 16'h3F01);
        offer_pair(10'd22, 10'd23, 16'hFFFF);
        drain_results();
        write_register(tcbp_pkg::CFG_TOP_K, 16'd0);
        write_register(tcbp_pkg::CFG_INIT_CUTOFF, 16'd0);
        offer_pair(10'd30, 10'd31, 16'h0101);
        offer_pair(10'd32, 10'd33, 16'h2080);
        offer_pair(10'd32, 10'd33, 16'h2081);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: takes result words with random stalls and checks each one.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        @(posedge rst_n);
        forever begin
            stall = out_lazy ? int'($urandom_range(0, MAX_GAP)) : 0;
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            board.check_word(out_data);
            if ($urandom_range(0, 29) == 0) out_lazy = !out_lazy;
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed words, then random phases. Each phase
    // starts from an idle block with a new top_k and initial cutoff, among them
    // the extremes, values just above the insert count (so rescans come often)
    // and a value below it (so no rescan comes until the count wraps).
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                          phase;
        logic [tcbp_pkg::TOPK_W-1:0] k;
        logic [tcbp_pkg::CUT_W-1:0]  c;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    k = board.inserts + tcbp_pkg::TOPK_W'($urandom_range(2, 24));
                    c = '0;
                end
                1: begin
                    k = '1;
                    c = '1;
                end
                2: begin
                    k = '0;
                    c = tcbp_pkg::CUT_W'($urandom_range(0, 63));
                end
                LOW_K_PHASE: begin
                    k = (board.inserts > 16'd1) ? 16'd1 : 16'd0;
                    c = '0;
                end
                4: begin
                    k = board.inserts + tcbp_pkg::TOPK_W'($urandom_range(1, 8));
                    c = tcbp_pkg::CUT_W'($urandom_range(0, 20));
                end
                5: begin
                    k = tcbp_pkg::TOPK_W'($urandom_range(1, 65535));
                    c = tcbp_pkg::CUT_W'($urandom_range(0, 63));
                end
                6: begin
                    k = board.inserts + tcbp_pkg::TOPK_W'($urandom_range(30, 300));
                    c = '0;
                end
                default: begin
                    k = tcbp_pkg::TOP_K_RESET;
                    c = tcbp_pkg::CUT_W'($urandom_range(0, 63));
                end
            endcase
            write_register(tcbp_pkg::CFG_TOP_K, k);
            write_register(tcbp_pkg::CFG_INIT_CUTOFF, tcbp_pkg::CFG_DAT_W'(c));
            repeat (PHASE_PAIRS) begin
                send_pair(make_pair(), next_gap());
                // Now and then the sender waits for the pipeline to empty.
                if ($urandom_range(0, 79) == 0) drain_results();
            end
        end

        drain_results();
        repeat (20) @(negedge clk);

        $display("Covered %0d pair words (%0d above the cutoff), %0d better-partner results,",
                 board.pairs, board.accepted, board.improvements);
        $display("%0d histogram rescans and %0d register writes, top_k 0 and 65535 among them.",
                 board.rescans, board.reg_writes);
        if (board.errors == 0) begin
            $display("topk_cutoff_best_partner_tracker_top_test passed");
        end else begin
            $display("topk_cutoff_best_partner_tracker_top_test failed");
        end
        $finish;
    end

endmodule

// ===== topk_cutoff_best_partner_tracker_top.f =====
src/tcbp_pkg.sv
src/tcbp_ram.sv
src/topk_cutoff_best_partner_tracker_top.sv
dv/topk_cutoff_best_partner_tracker_top_test.sv
